// ----- design/plcm_pkg.sv -----
// Shared types and constants for the piecewise linear curve map.
// Holds the controller state type, the command and status words, and field widths.
// No dependencies.
package plcm_pkg;

  // Field and port widths
  localparam int SAMPLE_W    = 32;
  localparam int SEG_W       = 3;
  localparam int COUNT_W     = 3;
  localparam int POINT_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - SEG_W - 2;

  // Bit positions of the result word
  localparam int OUT_SEG_LSB = SAMPLE_W;
  localparam int OUT_LO_BIT  = SAMPLE_W + SEG_W;
  localparam int OUT_HI_BIT  = SAMPLE_W + SEG_W + 1;

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_0     = 3'd1;

  localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 3'd2;
  localparam logic [COUNT_W-1:0] MIN_POINTS        = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ0,
    ST_FIRST,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take the sample, restart the walk
    logic rd;         // read the next curve point
    logic take_prev;  // current point becomes the previous one
    logic set_low;    // result clamped to the first point
    logic set_end;    // result is the last point
    logic capture;    // register interpolation operands
    logic div_start;  // multiply and start the division
    logic fin;        // add the quotient to y0
    logic out_load;   // move the result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic below;     // sample below the point just read
    logic hit;       // sample inside the current segment
    logic last;      // point just read is the last in use
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ----- design/plcm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the curve points. No dependencies.
module plcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 7
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/plcm_div.sv -----
// Restoring divider, one quotient bit per cycle, 64 / 32 bits.
// The dividend's upper word must be below the divisor, so the quotient fits 32 bits.
// Depends on plcm_pkg.
module plcm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quot,
  output logic        done
);

  localparam int DCNT_W = $clog2(plcm_pkg::DIV_STEPS);
  localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(plcm_pkg::DIV_STEPS - 1);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [31:0]       rem;
  logic [31:0]       q;
  logic [31:0]       dvsr;
  logic [33:0]       diff;
  logic              ge;
  logic [31:0]       rem_next;
  logic [31:0]       q_next;

  // Trial subtract of the shifted remainder
  always_comb begin
    diff     = {1'b0, rem, q[31]} - {2'b00, dvsr};
    ge       = ~diff[33];
    rem_next = ge ? diff[31:0] : {rem[30:0], q[31]};
    q_next   = {q[30:0], ge};
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[63:32];
      q    <= dividend[31:0];
      dvsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      q   <= q_next;
    end
  end

  assign quot = q;

endmodule

// ----- design/plcm_dpath.sv -----
// Datapath: configuration registers, point RAM, segment walk, multiplier,
// divider and output register. Driven by command words from plcm_ctrl.
// Depends on plcm_pkg, plcm_ram, plcm_div.
module plcm_dpath #(
  parameter int MAX_POINTS = 7
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [plcm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [plcm_pkg::IN_TDATA_W-1:0]        in_data,
  input  plcm_pkg::cmd_t                         cmd,
  output plcm_pkg::status_t                      status,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [plcm_pkg::OUT_TDATA_W-1:0]       out_data
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] N_MIN = CNT_W'(plcm_pkg::MIN_POINTS);

  // Configuration
  logic [plcm_pkg::COUNT_W-1:0]   point_count;
  logic [MAX_POINTS-1:0]          pt_valid;
  logic [plcm_pkg::CFG_IDX_W-1:0] wr_off;
  logic                           pt_we;
  logic [IDX_W-1:0]               pt_waddr;

  // Walk
  logic signed [31:0]             sample;
  logic [CNT_W-1:0]               n_eff;
  logic [CNT_W-1:0]               n_clamped;
  logic [CNT_W-1:0]               k;
  logic [plcm_pkg::POINT_W-1:0]   ram_q;
  logic                           rd_valid;
  logic [plcm_pkg::POINT_W-1:0]   cur;
  logic [plcm_pkg::POINT_W-1:0]   prev;
  logic signed [31:0]             cur_x;
  logic signed [31:0]             cur_y;
  logic signed [31:0]             prev_x;
  logic signed [31:0]             prev_y;

  // Interpolation operands
  logic [32:0]                    dxs_full;
  logic [32:0]                    dx_full;
  logic [32:0]                    dy_full;
  logic [32:0]                    mag_full;
  logic [31:0]                    op_dxs;
  logic [31:0]                    op_dx;
  logic [31:0]                    op_mag;
  logic                           op_neg;
  logic signed [31:0]             op_y0;
  logic [63:0]                    product;
  logic [31:0]                    quot;
  logic                           div_done;
  logic [32:0]                    y_sum;

  // Result
  logic [31:0]                    res_y;
  logic [plcm_pkg::SEG_W-1:0]     res_seg;
  logic                           res_lo;
  logic                           res_hi;

  // Point write decode; indexes past the stored points are dropped
  always_comb begin
    wr_off   = cfg_index - plcm_pkg::REG_POINT_0;
    pt_we    = cfg_we && (cfg_index != plcm_pkg::REG_POINT_COUNT)
               && (32'(wr_off) < MAX_POINTS);
    pt_waddr = IDX_W'(wr_off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= plcm_pkg::POINT_COUNT_RESET;
      pt_valid    <= '0;
    end else begin
      if (cfg_we && (cfg_index == plcm_pkg::REG_POINT_COUNT)) begin
        point_count <= cfg_data[plcm_pkg::COUNT_W-1:0];
      end
      if (pt_we) begin
        pt_valid[pt_waddr] <= 1'b1;
      end
    end
  end

  plcm_ram #(
    .WIDTH (plcm_pkg::POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (cfg_data),
    .re    (cmd.rd),
    .raddr (k[IDX_W-1:0]),
    .rdata (ram_q)
  );

  // Point never written reads as zero
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_valid <= pt_valid[k[IDX_W-1:0]];
    end
  end

  always_comb begin
    cur    = rd_valid ? ram_q : '0;
    cur_x  = cur[63:32];
    cur_y  = cur[31:0];
    prev_x = prev[63:32];
    prev_y = prev[31:0];
  end

  // Point count limited to 2..MAX_POINTS
  always_comb begin
    if (point_count < plcm_pkg::MIN_POINTS) begin
      n_clamped = N_MIN;
    end else if (32'(point_count) > MAX_POINTS) begin
      n_clamped = N_MAX;
    end else begin
      n_clamped = CNT_W'(point_count);
    end
  end

  // Sample, walk counter and previous point
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= in_data;
      n_eff  <= n_clamped;
      k      <= '0;
    end else if (cmd.rd) begin
      k <= k + 1'b1;
    end
    if (cmd.take_prev) begin
      prev <= cur;
    end
  end

  // Segment differences; on a hit dxs is non-negative and dx positive, |dy| < 2^32
  always_comb begin
    dxs_full = {sample[31], sample} - {prev_x[31], prev_x};
    dx_full  = {cur_x[31], cur_x} - {prev_x[31], prev_x};
    dy_full  = {cur_y[31], cur_y} - {prev_y[31], prev_y};
    mag_full = dy_full[32] ? (33'd0 - dy_full) : dy_full;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_dxs <= dxs_full[31:0];
      op_dx  <= dx_full[31:0];
      op_mag <= mag_full[31:0];
      op_neg <= dy_full[32];
      op_y0  <= prev_y;
    end
  end

  // Product goes straight into the divider's registers
  assign product = op_dxs * op_mag;

  plcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (product),
    .divisor  (op_dx),
    .quot     (quot),
    .done     (div_done)
  );

  assign y_sum = op_neg ? ({op_y0[31], op_y0} - {1'b0, quot})
                        : ({op_y0[31], op_y0} + {1'b0, quot});

  // Result staging
  always_ff @(posedge clk) begin
    if (cmd.set_low) begin
      res_y   <= cur_y;
      res_seg <= '0;
      res_lo  <= 1'b1;
      res_hi  <= 1'b0;
    end else if (cmd.set_end) begin
      res_y   <= cur_y;
      res_seg <= plcm_pkg::SEG_W'(n_eff - 1'b1);
      res_lo  <= 1'b0;
      res_hi  <= (sample >= cur_x);
    end else if (cmd.capture) begin
      res_seg <= plcm_pkg::SEG_W'(k - N_MIN);
      res_lo  <= 1'b0;
      res_hi  <= 1'b0;
    end else if (cmd.fin) begin
      res_y <= y_sum[31:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {{plcm_pkg::OUT_PAD_W{1'b0}}, res_hi, res_lo, res_seg, res_y};
    end
  end

  // Status back to the controller
  always_comb begin
    status.below    = (sample < cur_x);
    status.hit      = (sample >= prev_x) && (sample < cur_x);
    status.last     = (k == n_eff);
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ----- design/plcm_ctrl.sv -----
// Controller state machine: sequences the point walk, the multiply and
// divide, and the hand-over to the output register. Depends on plcm_pkg.
module plcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  plcm_pkg::status_t   status,
  output plcm_pkg::cmd_t      cmd,
  output plcm_pkg::state_t    state
);

  plcm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      plcm_pkg::ST_IDLE: begin
        if (in_valid) state_next = plcm_pkg::ST_READ0;
      end
      plcm_pkg::ST_READ0: begin
        state_next = plcm_pkg::ST_FIRST;
      end
      plcm_pkg::ST_FIRST: begin
        state_next = status.below ? plcm_pkg::ST_OUT : plcm_pkg::ST_WALK;
      end
      plcm_pkg::ST_WALK: begin
        priority if (status.hit) state_next = plcm_pkg::ST_MUL;
        else if (status.last)    state_next = plcm_pkg::ST_OUT;
        else                     state_next = plcm_pkg::ST_WALK;
      end
      plcm_pkg::ST_MUL: begin
        state_next = plcm_pkg::ST_DIV;
      end
      plcm_pkg::ST_DIV: begin
        if (status.div_done) state_next = plcm_pkg::ST_FIN;
      end
      plcm_pkg::ST_FIN: begin
        state_next = plcm_pkg::ST_OUT;
      end
      plcm_pkg::ST_OUT: begin
        if (status.out_free) state_next = plcm_pkg::ST_IDLE;
      end
      default: state_next = plcm_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      plcm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      plcm_pkg::ST_READ0: begin
        cmd.rd = 1'b1;
      end
      plcm_pkg::ST_FIRST: begin
        if (status.below) begin
          cmd.set_low = 1'b1;
        end else begin
          cmd.rd        = 1'b1;
          cmd.take_prev = 1'b1;
        end
      end
      plcm_pkg::ST_WALK: begin
        priority if (status.hit) begin
          cmd.capture = 1'b1;
        end else if (status.last) begin
          cmd.set_end = 1'b1;
        end else begin
          cmd.rd        = 1'b1;
          cmd.take_prev = 1'b1;
        end
      end
      plcm_pkg::ST_MUL: begin
        cmd.div_start = 1'b1;
      end
      plcm_pkg::ST_DIV: begin
      end
      plcm_pkg::ST_FIN: begin
        cmd.fin = 1'b1;
      end
      plcm_pkg::ST_OUT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/piecewise_linear_curve_map.sv -----
// Piecewise linear curve map: one word in, one word out, one word at a time.
// A result is clamped low at the first point, ends the walk at the last point, or is
// interpolated inside its segment. The walk reads one point a cycle from the point RAM;
// an interpolated result then waits for the 32-step divider.
// The input is ready again in the cycle after the previous result enters the output register.
// Synchronous reset: point count 2, all points zero, pipeline empty.
module piecewise_linear_curve_map #(
  parameter int MAX_POINTS = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration
  input  logic                                cfg_we,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [plcm_pkg::IN_TDATA_W-1:0]     s_tdata,   // [31:0] sample_x
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [plcm_pkg::OUT_TDATA_W-1:0]    m_tdata    // [31:0] mapped_y, [34:32] segment_used,
                                                         // [35] clamped_low, [36] clamped_high
);

  plcm_pkg::cmd_t    cmd;
  plcm_pkg::status_t status;
  plcm_pkg::state_t  state;

  plcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  plcm_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

`ifndef SYNTH
  // Never both clamp flags in one result
  a_one_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[plcm_pkg::OUT_LO_BIT] && m_tdata[plcm_pkg::OUT_HI_BIT]))
    else $error("both clamp flags set");

  // Low clamp always reports point 0
  a_low_seg: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[plcm_pkg::OUT_LO_BIT])
    |-> (m_tdata[plcm_pkg::OUT_HI_BIT-2:plcm_pkg::OUT_SEG_LSB] == '0))
    else $error("low clamp with nonzero segment");

  // A taken word closes the input until its result enters the output register
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input open while a word is in work");

  // Divider completes only while the controller waits for it
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == plcm_pkg::ST_DIV))
    else $error("divider done outside divide state");
`endif

endmodule
